### rtl/buddy_block_allocator_top_macros.svh
// ----------------------------------------------------------------------------
// buddy_block_allocator_top_macros
// Assertion helpers for the buddy allocator.
// ----------------------------------------------------------------------------
`ifndef BUDDY_BLOCK_ALLOCATOR_TOP_MACROS_SVH
`define BUDDY_BLOCK_ALLOCATOR_TOP_MACROS_SVH

// same-cycle implication
`define BBA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BBA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Types and constants shared by the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int HEAP_LOG2      = 16;
    localparam int MIN_BLOCK_LOG2 = 5;
    localparam int HEADER_BYTES   = 16;
    localparam int LEAF_LEVEL     = HEAP_LOG2 - MIN_BLOCK_LOG2;
    localparam int LVL_COUNT      = LEAF_LEVEL + 1;
    localparam int LVL_BITS       = $clog2(LVL_COUNT);
    localparam int NODE_BITS      = LEAF_LEVEL + 1;
    localparam int CNT_BITS       = LEAF_LEVEL + 1;
    localparam int ADDR_BITS      = 48;
    localparam int SIZE_BITS      = 32;
    localparam int LFB_BITS       = 23;

    localparam logic [ADDR_BITS-1:0] BASE_RESET = 48'h600000;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic                 op;
        logic [SIZE_BITS-1:0] request_size;
        logic [ADDR_BITS-1:0] release_address;
    } bba_req_t;

    typedef struct packed {
        logic [ADDR_BITS-1:0] granted_address;
        logic                 ok;
        logic [LFB_BITS-1:0]  largest_free_bytes;
    } bba_rsp_t;

    typedef struct packed {
        logic free_mark;
        logic alloc_mark;
    } bba_entry_t;

    typedef struct packed {
        logic                inc_en;
        logic [LVL_BITS-1:0] inc_lvl;
        logic                dec_en;
        logic [LVL_BITS-1:0] dec_lvl;
    } bba_cnt_upd_t;

    typedef struct packed {
        logic [LVL_COUNT-1:0] nonzero;
        logic [LFB_BITS-1:0]  largest_bytes;
    } bba_cnt_stat_t;

endpackage

### rtl/bba_node_ram.sv
// ----------------------------------------------------------------------------
// bba_node_ram
// Node mark memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module bba_node_ram
    import bba_pkg::*;
(
    input  logic                 clk,
    input  logic                 we,
    input  logic [NODE_BITS-1:0] waddr,
    input  bba_entry_t           wdata,
    input  logic [NODE_BITS-1:0] raddr,
    output bba_entry_t           rdata
);

    bba_entry_t mem [1 << NODE_BITS];
    bba_entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/bba_level_counts.sv
// ----------------------------------------------------------------------------
// bba_level_counts
// Free block count per tree level and the largest free block size.
// ----------------------------------------------------------------------------
module bba_level_counts
    import bba_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  bba_cnt_upd_t  upd,
    output bba_cnt_stat_t stat
);

    logic [CNT_BITS-1:0] cnt_reg  [LVL_COUNT];
    logic [CNT_BITS-1:0] cnt_next [LVL_COUNT];

    always_comb
    begin
        for (int l = 0; l < LVL_COUNT; l++)
        begin
            cnt_next[l] = cnt_reg[l];
            if (upd.inc_en && (upd.inc_lvl == LVL_BITS'(l)))
            begin
                cnt_next[l] = cnt_next[l] + CNT_BITS'(1);
            end
            if (upd.dec_en && (upd.dec_lvl == LVL_BITS'(l)))
            begin
                cnt_next[l] = cnt_next[l] - CNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int l = 0; l < LVL_COUNT; l++)
            begin
                cnt_reg[l] <= (l == 0) ? CNT_BITS'(1) : '0;
            end
        end
        else
        begin
            for (int l = 0; l < LVL_COUNT; l++)
            begin
                cnt_reg[l] <= cnt_next[l];
            end
        end
    end

    always_comb
    begin
        stat.largest_bytes = '0;
        for (int l = 0; l < LVL_COUNT; l++)
        begin
            stat.nonzero[l] = (cnt_reg[l] != '0);
        end
        // coarsest level with a free block wins
        for (int l = LVL_COUNT - 1; l >= 0; l--)
        begin
            if (stat.nonzero[l])
            begin
                stat.largest_bytes = LFB_BITS'(1) << (HEAP_LOG2 - l);
            end
        end
    end

endmodule

### rtl/buddy_block_allocator_top.sv
// Allocate scans the node memory at the chosen level, then splits down to the wanted level;
// the scan reads the node memory one entry a cycle, up to 2^level entries.
// Free probes each level from the root down, then merges with free buddies upward.
// One request is in flight at a time; a new one is taken as soon as the result is loaded.
// After reset a clearing pass writes every one of the 4096 node entries, no request taken.
// ----------------------------------------------------------------------------
// buddy_block_allocator_top
// Binary buddy allocator with node marks held in a synchronous memory.
// ----------------------------------------------------------------------------
`include "buddy_block_allocator_top_macros.svh"

module buddy_block_allocator_top
    import bba_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [ADDR_BITS-1:0] cfg_wdata,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  bba_req_t             in_req,
    output logic                 out_valid,
    input  logic                 out_stall,
    output bba_rsp_t             out_rsp
);

    typedef enum logic [10:0] {
        S_CLR      = 11'b00000000001,
        S_IDLE     = 11'b00000000010,
        S_APREP    = 11'b00000000100,
        S_SCAN     = 11'b00000001000,
        S_SPLIT    = 11'b00000010000,
        S_FREE_RD  = 11'b00000100000,
        S_FREE_CK  = 11'b00001000000,
        S_MERGE_RD = 11'b00010000000,
        S_MERGE_CK = 11'b00100000000,
        S_FIN      = 11'b01000000000,
        S_SPARE    = 11'b10000000000
    } state_t;

    state_t                state_reg, state_next;
    bba_req_t              req_reg, req_next;
    logic [ADDR_BITS-1:0]  base_reg;
    logic [NODE_BITS-1:0]  clr_ptr_reg, clr_ptr_next;
    logic [LVL_BITS-1:0]   want_reg, want_next;
    logic [LVL_BITS-1:0]   lvl_reg, lvl_next;
    logic [NODE_BITS-1:0]  node_reg, node_next;
    logic [NODE_BITS-1:0]  scan_ptr_reg, scan_ptr_next;
    logic                  chk_vld_reg, chk_vld_next;
    logic [NODE_BITS-1:0]  chk_addr_reg, chk_addr_next;
    logic                  ok_reg, ok_next;
    logic [HEAP_LOG2-1:0]  rel_reg, rel_next;
    logic                  out_valid_reg, out_valid_next;
    bba_rsp_t              out_reg, out_next;

    logic                  mem_we;
    logic [NODE_BITS-1:0]  mem_waddr;
    bba_entry_t            mem_wdata;
    logic [NODE_BITS-1:0]  mem_raddr;
    bba_entry_t            mem_rdata;
    bba_cnt_upd_t          cnt_upd;
    bba_cnt_stat_t         cnt_stat;

    logic [ADDR_BITS-1:0]  rel_full;
    logic [SIZE_BITS:0]    total;
    logic [LVL_BITS-1:0]   want_c;
    logic [LVL_BITS-1:0]   lvl_c;
    logic [HEAP_LOG2-1:0]  align_mask;
    logic [NODE_BITS-1:0]  free_node_c;
    logic [NODE_BITS-1:0]  idx_c;
    logic [HEAP_LOG2-1:0]  offset_c;

    bba_node_ram u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    bba_level_counts u_counts (
        .clk   (clk),
        .rst_n (rst_n),
        .upd   (cnt_upd),
        .stat  (cnt_stat)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_rsp   = out_reg;

    // header offset relative to the heap, modulo the address width
    assign rel_full = in_req.release_address - ADDR_BITS'(HEADER_BYTES) - base_reg;
    assign total    = {1'b0, req_reg.request_size} + (SIZE_BITS + 1)'(HEADER_BYTES);

    always_comb
    begin
        want_c = '0;
        lvl_c  = '0;
        for (int l = 0; l < LVL_COUNT; l++)
        begin
            if (((SIZE_BITS + 1)'(1) << (HEAP_LOG2 - l)) >= total)
            begin
                want_c = LVL_BITS'(l);
            end
        end
        // deepest level at or above the wanted one with a free block
        for (int l = 0; l < LVL_COUNT; l++)
        begin
            if ((LVL_BITS'(l) <= want_c) && cnt_stat.nonzero[l])
            begin
                lvl_c = LVL_BITS'(l);
            end
        end
    end

    assign align_mask  = ~({HEAP_LOG2{1'b1}} << (HEAP_LOG2 - int'(lvl_reg)));
    assign free_node_c = (NODE_BITS'(1) << lvl_reg)
                       | NODE_BITS'(rel_reg >> (HEAP_LOG2 - int'(lvl_reg)));
    assign idx_c       = node_reg ^ (NODE_BITS'(1) << want_reg);
    assign offset_c    = HEAP_LOG2'(idx_c) << (HEAP_LOG2 - int'(want_reg));

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        clr_ptr_next   = clr_ptr_reg;
        want_next      = want_reg;
        lvl_next       = lvl_reg;
        node_next      = node_reg;
        scan_ptr_next  = scan_ptr_reg;
        chk_vld_next   = chk_vld_reg;
        chk_addr_next  = chk_addr_reg;
        ok_next        = ok_reg;
        rel_next       = rel_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_next       = out_reg;
        mem_we         = 1'b0;
        mem_waddr      = node_reg;
        mem_wdata      = '0;
        mem_raddr      = node_reg;
        cnt_upd        = '0;

        case (state_reg)
            S_CLR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_ptr_reg;
                mem_wdata    = '{free_mark: (clr_ptr_reg == NODE_BITS'(1)), alloc_mark: 1'b0};
                clr_ptr_next = clr_ptr_reg + NODE_BITS'(1);
                if (clr_ptr_reg == {NODE_BITS{1'b1}})
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next = in_req;
                    lvl_next = '0;
                    if (in_req.op == OP_ALLOC)
                    begin
                        state_next = S_APREP;
                    end
                    else if (rel_full >= (ADDR_BITS'(1) << HEAP_LOG2))
                    begin
                        ok_next    = 1'b0;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        rel_next   = HEAP_LOG2'(rel_full);
                        state_next = S_FREE_RD;
                    end
                end
            end
            S_APREP:
            begin
                if ((cnt_stat.nonzero == '0)
                    || (total > (SIZE_BITS + 1)'(cnt_stat.largest_bytes)))
                begin
                    ok_next    = 1'b0;
                    state_next = S_FIN;
                end
                else
                begin
                    want_next     = want_c;
                    lvl_next      = lvl_c;
                    scan_ptr_next = NODE_BITS'(1) << lvl_c;
                    chk_vld_next  = 1'b0;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // one read issued per cycle, checked in the next cycle
                mem_raddr     = scan_ptr_reg;
                scan_ptr_next = scan_ptr_reg + NODE_BITS'(1);
                chk_vld_next  = 1'b1;
                chk_addr_next = scan_ptr_reg;
                if (chk_vld_reg && mem_rdata.free_mark)
                begin
                    mem_we          = 1'b1;
                    mem_waddr       = chk_addr_reg;
                    mem_wdata       = '0;
                    cnt_upd.dec_en  = 1'b1;
                    cnt_upd.dec_lvl = lvl_reg;
                    node_next       = chk_addr_reg;
                    state_next      = S_SPLIT;
                end
            end
            S_SPLIT:
            begin
                mem_we = 1'b1;
                if (lvl_reg == want_reg)
                begin
                    mem_waddr  = node_reg;
                    mem_wdata  = '{free_mark: 1'b0, alloc_mark: 1'b1};
                    ok_next    = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    // keep left half, free the right half
                    mem_waddr       = {node_reg[NODE_BITS-2:0], 1'b1};
                    mem_wdata       = '{free_mark: 1'b1, alloc_mark: 1'b0};
                    cnt_upd.inc_en  = 1'b1;
                    cnt_upd.inc_lvl = lvl_reg + LVL_BITS'(1);
                    node_next       = {node_reg[NODE_BITS-2:0], 1'b0};
                    lvl_next        = lvl_reg + LVL_BITS'(1);
                end
            end
            S_FREE_RD:
            begin
                if ((rel_reg & align_mask) == '0)
                begin
                    mem_raddr  = free_node_c;
                    node_next  = free_node_c;
                    state_next = S_FREE_CK;
                end
                else if (lvl_reg == LVL_BITS'(LEAF_LEVEL))
                begin
                    ok_next    = 1'b0;
                    state_next = S_FIN;
                end
                else
                begin
                    lvl_next = lvl_reg + LVL_BITS'(1);
                end
            end
            S_FREE_CK:
            begin
                if (mem_rdata.alloc_mark)
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = node_reg;
                    mem_wdata  = '0;
                    state_next = S_MERGE_RD;
                end
                else if (lvl_reg == LVL_BITS'(LEAF_LEVEL))
                begin
                    ok_next    = 1'b0;
                    state_next = S_FIN;
                end
                else
                begin
                    lvl_next   = lvl_reg + LVL_BITS'(1);
                    state_next = S_FREE_RD;
                end
            end
            S_MERGE_RD:
            begin
                if (lvl_reg == '0)
                begin
                    mem_we          = 1'b1;
                    mem_waddr       = node_reg;
                    mem_wdata       = '{free_mark: 1'b1, alloc_mark: 1'b0};
                    cnt_upd.inc_en  = 1'b1;
                    cnt_upd.inc_lvl = lvl_reg;
                    ok_next         = 1'b1;
                    state_next      = S_FIN;
                end
                else
                begin
                    mem_raddr  = node_reg ^ NODE_BITS'(1);
                    state_next = S_MERGE_CK;
                end
            end
            S_MERGE_CK:
            begin
                mem_we = 1'b1;
                if (mem_rdata.free_mark)
                begin
                    mem_waddr       = node_reg ^ NODE_BITS'(1);
                    mem_wdata       = '0;
                    cnt_upd.dec_en  = 1'b1;
                    cnt_upd.dec_lvl = lvl_reg;
                    node_next       = node_reg >> 1;
                    lvl_next        = lvl_reg - LVL_BITS'(1);
                    state_next      = S_MERGE_RD;
                end
                else
                begin
                    mem_waddr       = node_reg;
                    mem_wdata       = '{free_mark: 1'b1, alloc_mark: 1'b0};
                    cnt_upd.inc_en  = 1'b1;
                    cnt_upd.inc_lvl = lvl_reg;
                    ok_next         = 1'b1;
                    state_next      = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next             = 1'b1;
                    out_next.ok                = ok_reg;
                    out_next.largest_free_bytes = cnt_stat.largest_bytes;
                    if (ok_reg && (req_reg.op == OP_ALLOC))
                    begin
                        out_next.granted_address = base_reg + ADDR_BITS'(offset_c)
                                                 + ADDR_BITS'(HEADER_BYTES);
                    end
                    else
                    begin
                        out_next.granted_address = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_ptr_reg   <= '0;
            chk_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            base_reg      <= BASE_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            clr_ptr_reg   <= clr_ptr_next;
            chk_vld_reg   <= chk_vld_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                base_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        want_reg     <= want_next;
        lvl_reg      <= lvl_next;
        node_reg     <= node_next;
        scan_ptr_reg <= scan_ptr_next;
        chk_addr_reg <= chk_addr_next;
        ok_reg       <= ok_next;
        rel_reg      <= rel_next;
        out_reg      <= out_next;
    end

    `BBA_ASSERT_IMP(a_clr_blocks_requests, state_reg == S_CLR, in_stall, "request taken during clear")
    `BBA_ASSERT_IMP(a_refused_zero_addr, out_valid && !out_rsp.ok, out_rsp.granted_address == '0, "refused result carries an address")
    `BBA_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "second request taken while busy")

endmodule
